/* hdl/aba_pkg.sv */
`timescale 1ns / 1ps
// shared constants, types and helpers of the aligned block allocator
package aba_pkg;

    localparam int BLOCK_COUNT     = 256;
    localparam int RESERVED_BLOCKS = 48;
    localparam int BLOCK_BITS      = 12;
    localparam int OWNER_BITS      = 8;

    localparam int ADDR_W     = 20;
    localparam int SIZE_W     = 21;
    localparam int OWNER_IN_W = 8;

    localparam int TABLE_DEPTH = (BLOCK_COUNT > RESERVED_BLOCKS) ?
                                 (BLOCK_COUNT - RESERVED_BLOCKS) : 1;
    localparam int TAB_AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // block count scale of a request: (size - 1) >> BLOCK_BITS
    localparam int SCALE_W = SIZE_W - BLOCK_BITS;
    localparam int LOG_W   = $clog2(SCALE_W + 1);
    localparam int MAX_N   = 2 ** SCALE_W;
    localparam int CNT_W   = SCALE_W + 1;
    localparam int BLK_W   = $clog2(BLOCK_COUNT + RESERVED_BLOCKS
                                    + 2 ** (ADDR_W - BLOCK_BITS) + 4 * MAX_N) + 1;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef logic [OWNER_BITS-1:0] t_owner;
    typedef logic [BLK_W-1:0]      t_blk;
    typedef logic [TAB_AW-1:0]     t_tab_addr;
    typedef logic [LOG_W-1:0]      t_log;
    typedef logic [CNT_W-1:0]      t_cnt;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_SCAN,
        S_WRITE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic   action;
        t_owner owner;
        logic   addr_zero;
        t_blk   start_blk;
        t_log   log_n;
    } t_req;

    typedef struct packed {
        logic      rd_en;
        t_tab_addr rd_addr;
        logic      wr_en;
        t_tab_addr wr_addr;
        t_owner    wr_data;
    } t_ram_req;

    // log2 of the power-of-two block count for a byte size
    function automatic t_log round_log(input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0]  m1;
        logic [SCALE_W-1:0] s;
        t_log               l;
        m1 = size - SIZE_W'(1);
        s  = m1[SIZE_W-1:BLOCK_BITS];
        l  = '0;
        if (size != '0) begin
            for (int i = 0; i < SCALE_W; i++) begin
                if (s[i]) begin
                    l = t_log'(i + 1);
                end
            end
        end
        return l;
    endfunction

endpackage

/* hdl/aba_owner_ram.sv */
`timescale 1ns / 1ps
// owner table memory with per-entry valid bits, registered read
module aba_owner_ram (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  aba_pkg::t_ram_req i_req,
    output aba_pkg::t_owner   o_rd_data
);

    aba_pkg::t_owner r_mem [aba_pkg::TABLE_DEPTH];
    logic [aba_pkg::TABLE_DEPTH-1:0] r_vld;
    aba_pkg::t_owner r_rd_data;
    logic            r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    // an entry never written reads as free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_vld[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_vld[i_req.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

/* hdl/aba_seq.sv */
`timescale 1ns / 1ps
// sequencer: run search, table marking and freeing over the owner table
module aba_seq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_go,
    input  aba_pkg::t_req                i_req,
    input  aba_pkg::t_owner              i_rd_data,
    output aba_pkg::t_ram_req            o_ram,
    output logic                         o_busy,
    output logic                         o_done,
    output logic [aba_pkg::ADDR_W-1:0]   o_base_address,
    output logic                         o_found
);

    localparam aba_pkg::t_blk RES_BLK = aba_pkg::t_blk'(aba_pkg::RESERVED_BLOCKS);
    localparam aba_pkg::t_blk CNT_BLK = aba_pkg::t_blk'(aba_pkg::BLOCK_COUNT);

    aba_pkg::t_state r_state, n_state;
    aba_pkg::t_blk   r_base, n_base;
    aba_pkg::t_cnt   r_k, n_k;
    logic            r_pend, n_pend;
    logic            r_pend_last, n_pend_last;
    aba_pkg::t_blk   r_wblk, n_wblk;
    aba_pkg::t_blk   r_wend, n_wend;
    aba_pkg::t_owner r_wdata, n_wdata;
    logic [aba_pkg::ADDR_W-1:0] r_res_base, n_res_base;
    logic            r_res_found, n_res_found;

    aba_pkg::t_blk n_blk;
    aba_pkg::t_cnt n_cnt;
    aba_pkg::t_blk lo_blk, hi_raw, hi_blk, first_blk, next_blk, rd_blk;
    logic          rd_ok;
    logic [aba_pkg::BLK_W+aba_pkg::BLOCK_BITS-1:0] base_bytes;

    assign n_blk = aba_pkg::t_blk'(1) << i_req.log_n;
    assign n_cnt = aba_pkg::t_cnt'(1) << i_req.log_n;

    always_comb begin
        lo_blk     = (i_req.start_blk < RES_BLK) ? RES_BLK : i_req.start_blk;
        hi_raw     = i_req.start_blk + n_blk;
        hi_blk     = (hi_raw > CNT_BLK) ? CNT_BLK : hi_raw;
        // first aligned run at or above the reserved area
        first_blk  = ((RES_BLK + n_blk - aba_pkg::t_blk'(1)) >> i_req.log_n) << i_req.log_n;
        next_blk   = r_base + n_blk;
        rd_blk     = r_base + aba_pkg::t_blk'(r_k);
        rd_ok      = (i_rd_data == '0) || (i_rd_data == i_req.owner);
        base_bytes = {r_base, {aba_pkg::BLOCK_BITS{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aba_pkg::S_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base      <= n_base;
        r_k         <= n_k;
        r_pend_last <= n_pend_last;
        r_wblk      <= n_wblk;
        r_wend      <= n_wend;
        r_wdata     <= n_wdata;
        r_res_base  <= n_res_base;
        r_res_found <= n_res_found;
    end

    always_comb begin
        n_state     = r_state;
        n_base      = r_base;
        n_k         = r_k;
        n_pend      = 1'b0;
        n_pend_last = r_pend_last;
        n_wblk      = r_wblk;
        n_wend      = r_wend;
        n_wdata     = r_wdata;
        n_res_base  = r_res_base;
        n_res_found = r_res_found;
        o_ram       = '0;

        case (r_state)
            aba_pkg::S_IDLE: begin
                if (i_go) begin
                    n_state = aba_pkg::S_INIT;
                end
            end
            aba_pkg::S_INIT: begin
                n_res_base = '0;
                if (i_req.action == aba_pkg::ACT_FREE) begin
                    n_res_found = 1'b1;
                    if (lo_blk < hi_blk) begin
                        n_wblk  = lo_blk;
                        n_wend  = hi_blk;
                        n_wdata = '0;
                        n_state = aba_pkg::S_WRITE;
                    end else begin
                        n_state = aba_pkg::S_DONE;
                    end
                end else if (first_blk + n_blk > CNT_BLK) begin
                    n_res_found = 1'b0;
                    n_state     = aba_pkg::S_DONE;
                end else begin
                    n_base  = first_blk;
                    n_k     = '0;
                    n_state = aba_pkg::S_SCAN;
                end
            end
            aba_pkg::S_SCAN: begin
                // one read issued per cycle, checked the cycle after
                if (r_k < n_cnt) begin
                    o_ram.rd_en   = 1'b1;
                    o_ram.rd_addr = aba_pkg::t_tab_addr'(rd_blk - RES_BLK);
                    n_k           = r_k + aba_pkg::t_cnt'(1);
                    n_pend        = 1'b1;
                    n_pend_last   = (r_k == n_cnt - aba_pkg::t_cnt'(1));
                end
                if (r_pend) begin
                    if (!rd_ok) begin
                        // drop the read in flight and move to the next run
                        n_pend = 1'b0;
                        if (next_blk + n_blk > CNT_BLK) begin
                            n_res_base  = '0;
                            n_res_found = 1'b0;
                            n_state     = aba_pkg::S_DONE;
                        end else begin
                            n_base = next_blk;
                            n_k    = '0;
                        end
                    end else if (r_pend_last) begin
                        n_pend      = 1'b0;
                        n_res_base  = base_bytes[aba_pkg::ADDR_W-1:0];
                        n_res_found = 1'b1;
                        if (i_req.addr_zero) begin
                            n_wblk  = r_base;
                            n_wend  = next_blk;
                            n_wdata = i_req.owner;
                            n_state = aba_pkg::S_WRITE;
                        end else begin
                            n_state = aba_pkg::S_DONE;
                        end
                    end
                end
            end
            aba_pkg::S_WRITE: begin
                o_ram.wr_en   = 1'b1;
                o_ram.wr_addr = aba_pkg::t_tab_addr'(r_wblk - RES_BLK);
                o_ram.wr_data = r_wdata;
                n_wblk        = r_wblk + aba_pkg::t_blk'(1);
                if (n_wblk >= r_wend) begin
                    n_state = aba_pkg::S_DONE;
                end
            end
            aba_pkg::S_DONE: begin
                n_state = aba_pkg::S_IDLE;
            end
            default: begin
                n_state = aba_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy         = (r_state != aba_pkg::S_IDLE);
    assign o_done         = (r_state == aba_pkg::S_DONE);
    assign o_base_address = r_res_base;
    assign o_found        = r_res_found;

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_free_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && i_req.action == aba_pkg::ACT_FREE) |-> (o_found && o_base_address == '0))
        else $error("free must report found with zero base");

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ram.rd_en && o_ram.wr_en))
        else $error("table read and write in the same cycle");

    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_found) |-> (o_base_address == '0))
        else $error("failed allocation with nonzero base");

    a_go_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && r_state == aba_pkg::S_IDLE) |=> (r_state == aba_pkg::S_INIT))
        else $error("request not started");

endmodule

/* hdl/aligned_block_allocator.sv */
`timescale 1ns / 1ps
// Aligned block allocator with a per-block owner table. A request is taken when
// start is high and busy is low; busy then stays high until the result has been
// shown. The result is on o_base_address and o_found, marked by o_done for exactly
// one cycle, and the receiver cannot stall it. The owner table memory is
// read or written one block per cycle, and that port sets the length of a
// request: an allocate grows with the blocks read while searching and the blocks
// marked on a first allocation, out of 208 table blocks; a free grows with the
// blocks cleared. No clearing pass is needed after reset, the table reads as
// all free at once.
module aligned_block_allocator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_action,
    input  logic [aba_pkg::OWNER_IN_W-1:0]  i_owner,
    input  logic [aba_pkg::ADDR_W-1:0]      i_address,
    input  logic [aba_pkg::SIZE_W-1:0]      i_size_bytes,
    output logic                            o_done,
    output logic [aba_pkg::ADDR_W-1:0]      o_base_address,
    output logic                            o_found
);

    aba_pkg::t_req     r_req;
    logic              r_go;
    logic              seq_busy;
    aba_pkg::t_ram_req ram_req;
    aba_pkg::t_owner   rd_data;
    logic              accept;

    assign accept = start && !busy;
    assign busy   = r_go || seq_busy;

    // capture the request and round its size once per transfer
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.action    <= i_action;
            r_req.owner     <= i_owner[aba_pkg::OWNER_BITS-1:0];
            r_req.addr_zero <= (i_address == '0);
            r_req.start_blk <= aba_pkg::t_blk'(i_address[aba_pkg::ADDR_W-1:aba_pkg::BLOCK_BITS]);
            r_req.log_n     <= aba_pkg::round_log(i_size_bytes);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_go <= 1'b0;
        end else begin
            r_go <= accept;
        end
    end

    aba_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_go           (r_go),
        .i_req          (r_req),
        .i_rd_data      (rd_data),
        .o_ram          (ram_req),
        .o_busy         (seq_busy),
        .o_done         (o_done),
        .o_base_address (o_base_address),
        .o_found        (o_found)
    );

    aba_owner_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (ram_req),
        .o_rd_data (rd_data)
    );

endmodule
